[src/mrbp_pkg.sv]
// Shared types, constants and geometry helpers for the MaxRects bin packer.
// Used by mrbp_cfg, mrbp_engine and the top module under src; depends on nothing.
package mrbp_pkg;

  localparam int MAX_FREE_RECTS  = 64;
  localparam int COORD_BITS      = 16;
  localparam int LOG2_LIMIT      = ((COORD_BITS - 1) < 15) ? (COORD_BITS - 1) : 15;
  localparam int SCRATCH_SIZE    = MAX_FREE_RECTS * 4 + 2;
  localparam int FREE_AW         = $clog2(MAX_FREE_RECTS);
  localparam int FREE_CW         = $clog2(MAX_FREE_RECTS + 1);
  localparam int WORK_AW         = $clog2(SCRATCH_SIZE);
  localparam int WORK_CW         = $clog2(SCRATCH_SIZE + 1);
  localparam int FIELD_W         = 15;
  localparam int LOG_W           = 4;
  localparam int STATUS_W        = 2;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;
  localparam int P_W             = $clog2(LOG2_LIMIT + 2);
  localparam int INIT_LOG2_RESET = 6;
  localparam int INIT_LOG2_EFF   =
    (INIT_LOG2_RESET > LOG2_LIMIT) ? LOG2_LIMIT : INIT_LOG2_RESET;
  localparam int BOX_W           = 4 * COORD_BITS;

  // Register indexes
  localparam logic REG_INIT_LOG2 = 1'b0;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS:0]   ext_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } box_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED   = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_LIMIT    = 2'd2
  } status_t;

  // Restart command from the register block
  typedef struct packed {
    logic             restart;
    logic [LOG_W-1:0] lg;
  } cfg_cmd_t;

  function automatic ext_t right_of(box_t b);
    return {1'b0, b.x} + {1'b0, b.w};
  endfunction

  function automatic ext_t bottom_of(box_t b);
    return {1'b0, b.y} + {1'b0, b.h};
  endfunction

  function automatic logic overlaps(box_t a, box_t b);
    ext_t l, t, r, d;
    l = (a.x > b.x) ? {1'b0, a.x} : {1'b0, b.x};
    t = (a.y > b.y) ? {1'b0, a.y} : {1'b0, b.y};
    r = (right_of(a) < right_of(b)) ? right_of(a) : right_of(b);
    d = (bottom_of(a) < bottom_of(b)) ? bottom_of(a) : bottom_of(b);
    return (r > l) && (d > t);
  endfunction

  function automatic logic contains(box_t outer, box_t inner);
    return (inner.x >= outer.x) && (inner.y >= outer.y) &&
           (right_of(inner) <= right_of(outer)) &&
           (bottom_of(inner) <= bottom_of(outer));
  endfunction

  function automatic box_t full_bin(coord_t side);
    box_t b;
    b.x = '0;
    b.y = '0;
    b.w = side;
    b.h = side;
    return b;
  endfunction

endpackage

[src/mrbp_ram.sv]
// Generic simple dual-port RAM with registered read data.
// One write port and one read port; no dependencies.
module mrbp_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/mrbp_cfg.sv]
// APB register block of the bin packer: holds initial_size_log2 and issues
// the bin restart command. Depends on mrbp_pkg.
module mrbp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mrbp_pkg::PADDR_W-1:0]   paddr,
  input  logic [mrbp_pkg::PDATA_W-1:0]   pwdata,
  output logic [mrbp_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output mrbp_pkg::cfg_cmd_t             cmd
);
  import mrbp_pkg::*;

  logic [LOG_W-1:0] init_log2_r;
  logic             wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_INIT_LOG2);

  // Hold the register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_log2_r <= LOG_W'(INIT_LOG2_RESET);
    end else if (wr_hit) begin
      init_log2_r <= pwdata[LOG_W-1:0];
    end
  end

  // Restart with the clamped size
  always_comb begin
    cmd.restart = wr_hit;
    cmd.lg      = (pwdata[LOG_W-1:0] > LOG_W'(LOG2_LIMIT)) ? LOG_W'(LOG2_LIMIT)
                                                            : pwdata[LOG_W-1:0];
  end

  // Read back
  assign prdata = (paddr[2] == REG_INIT_LOG2) ? {{(PDATA_W-LOG_W){1'b0}}, init_log2_r}
                                              : '0;

endmodule

[src/mrbp_engine.sv]
// Placement sequencer: fit search, growth, split, prune and copy-back over
// the free rectangle store and two scratch memories. Depends on mrbp_pkg, mrbp_ram.
module mrbp_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mrbp_pkg::cfg_cmd_t              cmd,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mrbp_pkg::FIELD_W-1:0]    in_rect_width,
  input  logic [mrbp_pkg::FIELD_W-1:0]    in_rect_height,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mrbp_pkg::FIELD_W-1:0]    out_place_x,
  output logic [mrbp_pkg::FIELD_W-1:0]    out_place_y,
  output logic [mrbp_pkg::FIELD_W-1:0]    out_placed_width,
  output logic [mrbp_pkg::FIELD_W-1:0]    out_placed_height,
  output logic                            out_rotated,
  output logic [mrbp_pkg::LOG_W-1:0]      out_bin_size_log2,
  output logic [mrbp_pkg::STATUS_W-1:0]   out_status
);
  import mrbp_pkg::*;

  typedef enum logic [21:0] {
    S_INIT    = 22'h000001,
    S_IDLE    = 22'h000002,
    S_FIT_RD  = 22'h000004,
    S_FIT_EV  = 22'h000008,
    S_GR_INIT = 22'h000010,
    S_GR_P    = 22'h000020,
    S_ST_RD   = 22'h000040,
    S_ST_EV   = 22'h000080,
    S_S1_RD   = 22'h000100,
    S_S1_EV   = 22'h000200,
    S_S2_RD   = 22'h000400,
    S_S2_EV   = 22'h000800,
    S_S2_PUSH = 22'h001000,
    S_REM0    = 22'h002000,
    S_REM1    = 22'h004000,
    S_PR_ST   = 22'h008000,
    S_PR_RD   = 22'h010000,
    S_PR_EV   = 22'h020000,
    S_PR_END  = 22'h040000,
    S_CP_RD   = 22'h080000,
    S_CP_EV   = 22'h100000,
    S_DONE    = 22'h200000
  } state_t;

  state_t               state_r;
  logic [LOG_W-1:0]     log_r;
  coord_t               side_r;
  logic [FREE_CW-1:0]   cnt_r;
  logic [FREE_CW-1:0]   fi_r;
  logic [FREE_AW-1:0]   chosen_r;
  coord_t               w_r, h_r, need_r;
  box_t                 fbox_r;
  box_t                 placed_r;
  logic                 rot_r;
  status_t              status_r;
  logic [P_W-1:0]       p_r;
  coord_t               offset_r, newside_r;
  box_t                 e_r;
  logic [1:0]           k_r;
  logic [WORK_CW-1:0]   n_r, i_r, j_r, o_r;
  box_t                 cur_r;
  logic                 sel_r;

  logic                        out_valid_r, out_rot_r;
  logic                        out_valid_nxt;
  logic [FIELD_W-1:0]          out_x_r, out_y_r, out_w_r, out_h_r;
  logic [LOG_W-1:0]            out_log_r;
  logic [STATUS_W-1:0]         out_status_r;

  // Memory ports
  logic                 free_we;
  logic [FREE_AW-1:0]   free_waddr, free_raddr;
  box_t                 free_wdata, fq;
  logic                 wk_we, wk_dst;
  logic [WORK_AW-1:0]   wk_waddr, wk_raddr;
  box_t                 wk_wdata, wa_q, wb_q, wq;
  logic                 wa_we, wb_we;

  // Datapath helpers
  box_t                 stretched, part_box, rem0, rem1;
  logic                 part_ok, keep, ovl_q, q_in_cur, cur_in_q;
  ext_t                 pl, pt, pr, pd, er, ed, al, at, ar, ad;
  ext_t                 pow;
  logic [WORK_CW-1:0]   copy_lim;
  logic                 fits_up, fits_rot, in_fire;

  mrbp_ram #(.W(BOX_W), .DEPTH(MAX_FREE_RECTS)) u_free (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .raddr(free_raddr), .rdata(fq)
  );

  mrbp_ram #(.W(BOX_W), .DEPTH(SCRATCH_SIZE)) u_work_a (
    .clk(clk), .we(wa_we), .waddr(wk_waddr), .wdata(wk_wdata),
    .raddr(wk_raddr), .rdata(wa_q)
  );

  mrbp_ram #(.W(BOX_W), .DEPTH(SCRATCH_SIZE)) u_work_b (
    .clk(clk), .we(wb_we), .waddr(wk_waddr), .wdata(wk_wdata),
    .raddr(wk_raddr), .rdata(wb_q)
  );

  // Route scratch traffic: sel_r names the source list, the other is the target
  assign wa_we = wk_we && !(sel_r ^ wk_dst);
  assign wb_we = wk_we && (sel_r ^ wk_dst);
  assign wq    = sel_r ? wb_q : wa_q;

  assign in_stall = (state_r != S_IDLE) || cmd.restart;
  assign in_fire  = in_valid && !in_stall;

  // Fit tests and stretch of the word read from the free store
  always_comb begin
    fits_up  = (fq.w >= w_r) && (fq.h >= h_r);
    fits_rot = (fq.w >= h_r) && (fq.h >= w_r);
    stretched = fq;
    if (right_of(fq) >= {1'b0, side_r}) begin
      stretched.w = fq.w + offset_r;
    end
    if (bottom_of(fq) >= {1'b0, side_r}) begin
      stretched.h = fq.h + offset_r;
    end
    ovl_q = overlaps(placed_r, fq);
    keep  = (fi_r[FREE_AW-1:0] != chosen_r) && !ovl_q;
    pow   = ext_t'(1) << p_r;
  end

  // Split parts of the overlapped word, one per push cycle
  always_comb begin
    er = right_of(e_r);
    ed = bottom_of(e_r);
    pl = (placed_r.x > e_r.x) ? {1'b0, placed_r.x} : {1'b0, e_r.x};
    pt = (placed_r.y > e_r.y) ? {1'b0, placed_r.y} : {1'b0, e_r.y};
    pr = (right_of(placed_r) < er) ? right_of(placed_r) : er;
    pd = (bottom_of(placed_r) < ed) ? bottom_of(placed_r) : ed;
    case (k_r)
      2'd0: begin
        al = {1'b0, e_r.x}; at = {1'b0, e_r.y}; ar = pl; ad = ed;
      end
      2'd1: begin
        al = {1'b0, e_r.x}; at = {1'b0, e_r.y}; ar = er; ad = pt;
      end
      2'd2: begin
        al = pr; at = {1'b0, e_r.y}; ar = er; ad = ed;
      end
      default: begin
        al = {1'b0, e_r.x}; at = pd; ar = er; ad = ed;
      end
    endcase
    part_ok    = (ar > al) && (ad > at);
    part_box.x = al[COORD_BITS-1:0];
    part_box.y = at[COORD_BITS-1:0];
    part_box.w = coord_t'(ar - al);
    part_box.h = coord_t'(ad - at);
  end

  // Guillotine remainders (bottom first, then right), prune containment tests and copy-back limit
  always_comb begin
    rem0.x = placed_r.x;
    rem0.y = placed_r.y + placed_r.h;
    rem0.w = fbox_r.w;
    rem0.h = fbox_r.h - placed_r.h;
    rem1.x = placed_r.x + placed_r.w;
    rem1.y = placed_r.y;
    rem1.w = fbox_r.w - placed_r.w;
    rem1.h = fbox_r.h;
    q_in_cur = contains(cur_r, wq);
    cur_in_q = contains(wq, cur_r);
    copy_lim = (n_r > WORK_CW'(MAX_FREE_RECTS)) ? WORK_CW'(MAX_FREE_RECTS) : n_r;
  end

  // Drive memory ports per state; a restart writes the new full-bin entry at address 0
  always_comb begin
    free_we    = 1'b0;
    free_waddr = '0;
    free_wdata = fq;
    free_raddr = fi_r[FREE_AW-1:0];
    wk_we      = 1'b0;
    wk_dst     = 1'b0;
    wk_waddr   = n_r[WORK_AW-1:0];
    wk_wdata   = fq;
    wk_raddr   = j_r[WORK_AW-1:0];
    unique case (state_r)
      S_INIT: begin
        free_we    = 1'b1;
        free_wdata = full_bin(side_r);
      end
      S_ST_EV: begin
        free_we    = 1'b1;
        free_waddr = fi_r[FREE_AW-1:0];
        free_wdata = stretched;
      end
      S_S1_EV: begin
        wk_we = keep;
      end
      S_S2_PUSH: begin
        wk_we    = part_ok;
        wk_wdata = part_box;
      end
      S_REM0: begin
        wk_we    = 1'b1;
        wk_wdata = rem0;
      end
      S_REM1: begin
        wk_we    = 1'b1;
        wk_wdata = rem1;
      end
      S_PR_EV: begin
        wk_dst   = 1'b1;
        wk_waddr = o_r[WORK_AW-1:0];
        wk_wdata = wq;
        wk_we    = (j_r < i_r) || ((j_r > i_r) && !q_in_cur && !cur_in_q);
      end
      S_PR_END: begin
        wk_we    = 1'b1;
        wk_dst   = 1'b1;
        wk_waddr = i_r[WORK_AW-1:0];
        wk_wdata = cur_r;
      end
      S_CP_EV: begin
        free_we    = 1'b1;
        free_waddr = j_r[FREE_AW-1:0];
        free_wdata = wq;
      end
      default: ;
    endcase
    if (cmd.restart) begin
      free_we    = 1'b1;
      free_waddr = '0;
      free_wdata = full_bin(coord_t'(1) << cmd.lg);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      log_r       <= LOG_W'(INIT_LOG2_EFF);
      side_r      <= coord_t'(1) << INIT_LOG2_EFF;
      cnt_r       <= FREE_CW'(1);
      sel_r       <= 1'b0;
    end else if (cmd.restart) begin
      // Restart the bin on a register write
      log_r  <= cmd.lg;
      side_r <= coord_t'(1) << cmd.lg;
      cnt_r  <= FREE_CW'(1);
    end else begin
      unique case (state_r)
        S_INIT: begin
          state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            w_r     <= coord_t'(in_rect_width);
            h_r     <= coord_t'(in_rect_height);
            need_r  <= coord_t'((in_rect_width > in_rect_height) ? in_rect_width
                                                                  : in_rect_height);
            fi_r    <= '0;
            state_r <= S_FIT_RD;
          end
        end
        S_FIT_RD: begin
          state_r <= (fi_r == cnt_r) ? S_GR_INIT : S_FIT_EV;
        end
        S_FIT_EV: begin
          if (fits_up || fits_rot) begin
            chosen_r   <= fi_r[FREE_AW-1:0];
            fbox_r     <= fq;
            rot_r      <= !fits_up;
            placed_r.x <= fq.x;
            placed_r.y <= fq.y;
            placed_r.w <= fits_up ? w_r : h_r;
            placed_r.h <= fits_up ? h_r : w_r;
            status_r   <= ST_PLACED;
            fi_r       <= '0;
            n_r        <= '0;
            state_r    <= S_S1_RD;
          end else begin
            fi_r    <= fi_r + 1'b1;
            state_r <= S_FIT_RD;
          end
        end
        S_GR_INIT: begin
          p_r     <= P_W'(log_r) + 1'b1;
          state_r <= S_GR_P;
        end
        S_GR_P: begin
          if (p_r > P_W'(LOG2_LIMIT)) begin
            placed_r <= '0;
            rot_r    <= 1'b0;
            status_r <= ST_LIMIT;
            state_r  <= S_DONE;
          end else if (pow < {1'b0, need_r}) begin
            p_r <= p_r + 1'b1;
          end else begin
            newside_r <= pow[COORD_BITS-1:0];
            offset_r  <= pow[COORD_BITS-1:0] - side_r;
            fi_r      <= '0;
            state_r   <= S_ST_RD;
          end
        end
        S_ST_RD: begin
          if (fi_r == cnt_r) begin
            side_r  <= newside_r;
            log_r   <= p_r[LOG_W-1:0];
            fi_r    <= '0;
            state_r <= S_FIT_RD;
          end else begin
            state_r <= S_ST_EV;
          end
        end
        S_ST_EV: begin
          fi_r    <= fi_r + 1'b1;
          state_r <= S_ST_RD;
        end
        S_S1_RD: begin
          if (fi_r == cnt_r) begin
            fi_r    <= '0;
            state_r <= S_S2_RD;
          end else begin
            state_r <= S_S1_EV;
          end
        end
        S_S1_EV: begin
          if (keep) begin
            n_r <= n_r + 1'b1;
          end
          fi_r    <= fi_r + 1'b1;
          state_r <= S_S1_RD;
        end
        S_S2_RD: begin
          state_r <= (fi_r == cnt_r) ? S_REM0 : S_S2_EV;
        end
        S_S2_EV: begin
          if ((fi_r[FREE_AW-1:0] != chosen_r) && ovl_q) begin
            e_r     <= fq;
            k_r     <= '0;
            state_r <= S_S2_PUSH;
          end else begin
            fi_r    <= fi_r + 1'b1;
            state_r <= S_S2_RD;
          end
        end
        S_S2_PUSH: begin
          if (part_ok) begin
            n_r <= n_r + 1'b1;
          end
          if (k_r == 2'd3) begin
            fi_r    <= fi_r + 1'b1;
            state_r <= S_S2_RD;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_REM0: begin
          n_r     <= n_r + 1'b1;
          state_r <= S_REM1;
        end
        S_REM1: begin
          n_r     <= n_r + 1'b1;
          i_r     <= '0;
          state_r <= S_PR_ST;
        end
        S_PR_ST: begin
          j_r     <= '0;
          o_r     <= '0;
          state_r <= (i_r >= n_r) ? S_CP_RD : S_PR_RD;
        end
        S_PR_RD: begin
          state_r <= (j_r == n_r) ? S_PR_END : S_PR_EV;
        end
        S_PR_EV: begin
          // Keep words ahead of the pivot, fold contained ones into it
          if (j_r < i_r) begin
            o_r <= o_r + 1'b1;
          end else if (j_r == i_r) begin
            cur_r <= wq;
            o_r   <= i_r + 1'b1;
          end else if (q_in_cur) begin
            o_r <= o_r;
          end else if (cur_in_q) begin
            cur_r <= wq;
          end else begin
            o_r <= o_r + 1'b1;
          end
          j_r     <= j_r + 1'b1;
          state_r <= S_PR_RD;
        end
        S_PR_END: begin
          n_r     <= o_r;
          sel_r   <= !sel_r;
          i_r     <= i_r + 1'b1;
          state_r <= S_PR_ST;
        end
        S_CP_RD: begin
          if (j_r == copy_lim) begin
            cnt_r    <= copy_lim[FREE_CW-1:0];
            status_r <= (n_r > WORK_CW'(MAX_FREE_RECTS)) ? ST_OVERFLOW : ST_PLACED;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_CP_EV;
          end
        end
        S_CP_EV: begin
          j_r     <= j_r + 1'b1;
          state_r <= S_CP_RD;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_x_r      <= placed_r.x[FIELD_W-1:0];
            out_y_r      <= placed_r.y[FIELD_W-1:0];
            out_w_r      <= placed_r.w[FIELD_W-1:0];
            out_h_r      <= placed_r.h[FIELD_W-1:0];
            out_rot_r    <= rot_r;
            out_log_r    <= log_r;
            out_status_r <= status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Raise valid when a result is loaded, drop it once taken
  assign out_valid_nxt = (state_r == S_DONE) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_place_x       = out_x_r;
  assign out_place_y       = out_y_r;
  assign out_placed_width  = out_w_r;
  assign out_placed_height = out_h_r;
  assign out_rotated       = out_rot_r;
  assign out_bin_size_log2 = out_log_r;
  assign out_status        = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FREE_CW'(MAX_FREE_RECTS))
    else $error("free count exceeds store depth");

  a_rem_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REM0 |-> n_r <= WORK_CW'(SCRATCH_SIZE - 2))
    else $error("no room for remainders");

  a_prune_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PR_EV |-> (j_r < n_r) && (o_r <= j_r))
    else $error("prune write pointer overtook read pointer");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_FIT_RD)
    else $error("accepted word did not start a fit search");

  a_log_bound: assert property (@(posedge clk) disable iff (!rst_n)
    log_r <= LOG_W'(LOG2_LIMIT))
    else $error("bin size beyond limit");

endmodule

[src/maxrects_bin_packer_top.sv]
// MaxRects bin packer: places one rectangle per input word in a square bin.
// Input channel in_* carries rect_width/rect_height; output channel out_*
// carries the placement, rotation flag, bin size and status (0 placed,
// 1 free list overflowed, 2 size limit reached and not placed).
// Both channels use valid/stall; a word moves when valid is high and stall low.
// The APB port holds initial_size_log2 at address 0; writing it restarts the
// bin with one free rectangle of that size (clamped to 2^15).
// After reset the block writes the full-bin entry in its init state, then
// takes input. One word is processed at a time: with C free rectangles the
// fit search reads and evaluates each entry scanned, each growth step adds a
// stretch pass over all C entries, split pushes up to four parts for each of
// S overlapped entries, and the prune pass over the N-entry scratch list
// reads it once per pivot and dominates. Copy-back moves min(N,64) entries.
// Every pass is bounded by the one-read-per-cycle port of the memories.
// A finished result sits in the output register; the next word may be taken
// while it waits, and a stalled receiver only delays the following result.
// Depends on mrbp_pkg, mrbp_cfg, mrbp_engine, mrbp_ram.
module maxrects_bin_packer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mrbp_pkg::FIELD_W-1:0]    in_rect_width,
  input  logic [mrbp_pkg::FIELD_W-1:0]    in_rect_height,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mrbp_pkg::FIELD_W-1:0]    out_place_x,
  output logic [mrbp_pkg::FIELD_W-1:0]    out_place_y,
  output logic [mrbp_pkg::FIELD_W-1:0]    out_placed_width,
  output logic [mrbp_pkg::FIELD_W-1:0]    out_placed_height,
  output logic                            out_rotated,
  output logic [mrbp_pkg::LOG_W-1:0]      out_bin_size_log2,
  output logic [mrbp_pkg::STATUS_W-1:0]   out_status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mrbp_pkg::PADDR_W-1:0]    paddr,
  input  logic [mrbp_pkg::PDATA_W-1:0]    pwdata,
  output logic [mrbp_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import mrbp_pkg::*;

  cfg_cmd_t cmd;

  mrbp_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cmd(cmd)
  );

  mrbp_engine u_engine (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_rect_width(in_rect_width), .in_rect_height(in_rect_height),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_place_x(out_place_x), .out_place_y(out_place_y),
    .out_placed_width(out_placed_width), .out_placed_height(out_placed_height),
    .out_rotated(out_rotated), .out_bin_size_log2(out_bin_size_log2),
    .out_status(out_status)
  );

endmodule
